// File: rtl/core/kfcv_pkg.sv
// Shared constants, codes and types for the 2-D constant-velocity Kalman filter.
`timescale 1ns / 1ps
`default_nettype none

package kfcv_pkg;

  // Default word geometry: signed words with a binary point above FRAC bits.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Widths fixed by the stream and configuration ports.
  localparam int IO_BITS  = 32;
  localparam int CFG_BITS = 31;

  // One lane per state element.
  localparam int NLANES = 4;

  // Noise registers come out of reset at 0.1 in Q16.16.
  localparam logic [CFG_BITS-1:0] NOISE_RESET = CFG_BITS'(6554);

  // Kind of request carried in tuser.
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_IDX_Q = 1'b0;
  localparam logic CFG_IDX_R = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // Per-lane control issued by the sequencer.
  typedef struct packed {
    logic mac_go;
    logic sub;
    logic div_go;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/kfcv_lane.sv
// One arithmetic lane: saturating fixed-point multiply-accumulate and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module kfcv_lane
  import kfcv_pkg::*;
#(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lane_ctl_t           ctl,
  input  wire logic signed [W-1:0] op_a,
  input  wire logic signed [W-1:0] op_b,
  input  wire logic signed [W-1:0] op_c,
  output logic signed [W-1:0]      res,
  output logic                     res_sat,
  input  wire logic signed [W-1:0] div_num,
  input  wire logic signed [W-1:0] div_den,
  output logic signed [W-1:0]      div_q,
  output logic                     div_sat,
  output logic                     div_busy
);

  localparam int QB = W + F;
  localparam int CB = $clog2(QB + 1);
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] WMAX = LIM_POS;
  localparam logic signed [W-1:0] WMIN = LIM_NEG;

  function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
    return v[W-1] ? W'(~v + 1'b1) : W'(v);
  endfunction

  // Product of magnitudes, scaled down and saturated with the sign restored.
  logic [W-1:0]        ma, mb;
  logic [2*W-1:0]      prod, prod_sh;
  logic                mneg, mover;
  logic signed [W-1:0] mval;

  always_comb begin
    ma      = magw(op_a);
    mb      = magw(op_b);
    prod    = (2*W)'(ma) * (2*W)'(mb);
    prod_sh = prod >> F;
    mneg    = op_a[W-1] ^ op_b[W-1];
    mover   = (prod_sh[2*W-1:W] != '0) ||
              (prod_sh[W-1:0] > (mneg ? LIM_NEG : LIM_POS));
    if (mover) begin
      mval = mneg ? WMIN : WMAX;
    end else if (mneg) begin
      mval = $signed(W'(~prod_sh[W-1:0] + 1'b1));
    end else begin
      mval = $signed(prod_sh[W-1:0]);
    end
  end

  // Stage one holds the product, stage two the saturated sum.
  logic signed [W-1:0] p1, c1;
  logic                p1_sat, sub1, v1;
  logic signed [W:0]   sum;
  logic                aover;
  logic signed [W-1:0] sval;

  always_comb begin
    if (sub1) begin
      sum = (W+1)'(c1) - (W+1)'(p1);
    end else begin
      sum = (W+1)'(c1) + (W+1)'(p1);
    end
    aover = sum[W] != sum[W-1];
    if (aover) begin
      sval = sum[W] ? WMIN : WMAX;
    end else begin
      sval = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.mac_go;
    end
    if (ctl.mac_go) begin
      p1     <= mval;
      p1_sat <= mover;
      c1     <= op_c;
      sub1   <= ctl.sub;
    end
    if (v1) begin
      res     <= sval;
      res_sat <= p1_sat | aover;
    end
  end

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of sh while quotient bits enter at the bottom.
  logic [QB-1:0] sh;
  logic [W-1:0]  rem, dmag;
  logic          dneg;
  logic [CB-1:0] cnt;
  logic [W:0]    trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem, sh[QB-1]};
    diff  = trial - {1'b0, dmag};
    ge    = trial >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.div_go) begin
      cnt <= CB'(QB);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
    if (ctl.div_go) begin
      sh   <= {magw(div_num), {F{1'b0}}};
      rem  <= '0;
      dmag <= magw(div_den);
      dneg <= div_num[W-1] ^ div_den[W-1];
    end else if (cnt != '0) begin
      rem <= ge ? diff[W-1:0] : trial[W-1:0];
      sh  <= {sh[QB-2:0], ge};
    end
  end

  // Quotient saturation to the word range.
  always_comb begin
    div_busy = cnt != '0;
    div_sat  = (sh[QB-1:W] != '0) || (sh[W-1:0] > (dneg ? LIM_NEG : LIM_POS));
    if (div_sat) begin
      div_q = dneg ? WMIN : WMAX;
    end else if (dneg) begin
      div_q = $signed(W'(~sh[W-1:0] + 1'b1));
    end else begin
      div_q = $signed(sh[W-1:0]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kfcv_core.sv
// Filter sequencer: holds state and covariance, drives the four lanes and merges their results.
`timescale 1ns / 1ps
`default_nettype none

module kfcv_core
  import kfcv_pkg::*;
#(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                func,
  input  wire logic signed [W-1:0] zx,
  input  wire logic signed [W-1:0] zy,
  input  wire logic                z_sat,
  input  wire logic signed [W-1:0] q_noise,
  input  wire logic signed [W-1:0] r_noise,
  output logic                     idle,
  output logic                     done,
  input  wire logic                ack,
  output logic signed [W-1:0]      est [NLANES],
  output logic [1:0]               status
);

  localparam logic signed [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << F;

  // Microcode step numbers; the covariance product occupies a block of
  // sixteen so that its term and column come straight from the low bits.
  localparam logic [5:0] PR_X     = 6'd0;
  localparam logic [5:0] PR_R0    = 6'd1;
  localparam logic [5:0] PR_R1    = 6'd2;
  localparam logic [5:0] PR_C0    = 6'd3;
  localparam logic [5:0] PR_C1    = 6'd4;
  localparam logic [5:0] PR_DQ    = 6'd5;
  localparam logic [5:0] U_Y      = 6'd8;
  localparam logic [5:0] U_DM     = 6'd9;
  localparam logic [5:0] U_DET    = 6'd10;
  localparam logic [5:0] K0A      = 6'd11;
  localparam logic [5:0] K0B      = 6'd12;
  localparam logic [5:0] K1A      = 6'd13;
  localparam logic [5:0] K1B      = 6'd14;
  localparam logic [5:0] KYA      = 6'd15;
  localparam logic [5:0] KYB      = 6'd16;
  localparam logic [5:0] IK0      = 6'd17;
  localparam logic [5:0] IK1      = 6'd18;
  localparam logic [5:0] PN_FIRST = 6'd32;
  localparam logic [5:0] PN_LAST  = 6'd47;
  localparam logic [5:0] FIN      = 6'd48;
  localparam logic [1:0] PH_LAST  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DIVGO,
    S_DIVWAIT,
    S_HOLD
  } state_t;

  state_t              state;
  logic [5:0]          stp, stp_next;
  logic [1:0]          ph;
  logic                sat_acc, sat_now, func_q;
  logic signed [W-1:0] zx_q, zy_q;

  // Filter state and working values.
  logic signed [W-1:0] x [NLANES];
  logic signed [W-1:0] p [NLANES][NLANES];
  logic signed [W-1:0] t [NLANES][NLANES];
  logic signed [W-1:0] kk [NLANES][2];
  logic signed [W-1:0] ky [NLANES];
  logic signed [W-1:0] y0, y1, s0, s3, m0, m1, ns1, ns2, det;
  logic signed [W-1:0] si [NLANES];

  // Lane interface.
  lane_ctl_t           ctl [NLANES];
  logic signed [W-1:0] op_a [NLANES];
  logic signed [W-1:0] op_b [NLANES];
  logic signed [W-1:0] op_c [NLANES];
  logic signed [W-1:0] res [NLANES];
  logic signed [W-1:0] dnum [NLANES];
  logic signed [W-1:0] div_q [NLANES];
  logic [NLANES-1:0]   lane_sat, div_sat, div_busy;
  logic [1:0]          pn_k, pn_j;
  logic                issue;

  assign pn_k  = stp[1:0];
  assign pn_j  = stp[3:2];
  assign issue = (state == S_STEP) && (ph == 2'd0);

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    kfcv_lane #(.W(W), .F(F)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[g]),
      .op_a    (op_a[g]),
      .op_b    (op_b[g]),
      .op_c    (op_c[g]),
      .res     (res[g]),
      .res_sat (lane_sat[g]),
      .div_num (dnum[g]),
      .div_den (det),
      .div_q   (div_q[g]),
      .div_sat (div_sat[g]),
      .div_busy(div_busy[g])
    );
  end

  // Operand selection for each step.
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
      op_c[i] = '0;
      ctl[i]  = '{mac_go: issue, sub: 1'b0, div_go: state == S_DIVGO};
    end
    dnum[0] = s3;
    dnum[1] = ns1;
    dnum[2] = ns2;
    dnum[3] = s0;
    unique case (stp) inside
      PR_X: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = x[i];
          op_b[i] = ONE;
        end
        op_a[0] = x[2];
        op_a[1] = x[3];
      end
      PR_R0: begin
        for (int j = 0; j < NLANES; j++) begin
          op_c[j] = p[0][j];
          op_a[j] = p[2][j];
          op_b[j] = ONE;
        end
      end
      PR_R1: begin
        for (int j = 0; j < NLANES; j++) begin
          op_c[j] = p[1][j];
          op_a[j] = p[3][j];
          op_b[j] = ONE;
        end
      end
      PR_C0: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = p[i][0];
          op_a[i] = p[i][2];
          op_b[i] = ONE;
        end
      end
      PR_C1: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = p[i][1];
          op_a[i] = p[i][3];
          op_b[i] = ONE;
        end
      end
      PR_DQ: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = p[i][i];
          op_a[i] = q_noise;
          op_b[i] = ONE;
        end
      end
      U_Y: begin
        op_c[0] = zx_q;
        op_a[0] = x[0];
        op_c[1] = zy_q;
        op_a[1] = x[1];
        op_c[2] = p[0][0];
        op_a[2] = r_noise;
        op_c[3] = p[1][1];
        op_a[3] = r_noise;
        for (int i = 0; i < NLANES; i++) begin
          op_b[i] = ONE;
        end
        ctl[0].sub = 1'b1;
        ctl[1].sub = 1'b1;
      end
      U_DM: begin
        op_a[0] = s0;
        op_b[0] = s3;
        op_a[1] = p[0][1];
        op_b[1] = p[1][0];
        op_a[2] = p[0][1];
        op_b[2] = ONE;
        op_a[3] = p[1][0];
        op_b[3] = ONE;
        ctl[2].sub = 1'b1;
        ctl[3].sub = 1'b1;
      end
      U_DET: begin
        op_c[0] = m0;
        op_a[0] = m1;
        op_b[0] = ONE;
        ctl[0].sub = 1'b1;
      end
      K0A, K0B, K1A, K1B: begin
        for (int i = 0; i < NLANES; i++) begin
          op_a[i] = stp[0] ? p[i][0] : p[i][1];
          op_c[i] = stp[0] ? '0 : res[i];
        end
        for (int i = 0; i < NLANES; i++) begin
          unique case (stp)
            K0A:     op_b[i] = si[0];
            K0B:     op_b[i] = si[2];
            K1A:     op_b[i] = si[1];
            default: op_b[i] = si[3];
          endcase
        end
      end
      KYA: begin
        for (int i = 0; i < NLANES; i++) begin
          op_a[i] = kk[i][0];
          op_b[i] = y0;
        end
      end
      KYB: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = res[i];
          op_a[i] = kk[i][1];
          op_b[i] = y1;
        end
      end
      IK0, IK1: begin
        for (int i = 0; i < NLANES; i++) begin
          op_a[i]    = stp[0] ? kk[i][0] : kk[i][1];
          op_b[i]    = ONE;
          op_c[i]    = ((stp[0] && i == 0) || (!stp[0] && i == 1)) ? ONE : '0;
          ctl[i].sub = 1'b1;
        end
      end
      [PN_FIRST:PN_LAST]: begin
        for (int i = 0; i < NLANES; i++) begin
          if (pn_k[1]) begin
            op_a[i] = (pn_k == 2'(i)) ? ONE : '0;
          end else begin
            op_a[i] = kk[i][pn_k[0]];
          end
          op_b[i] = p[pn_k][pn_j];
          op_c[i] = (pn_k == 2'd0) ? '0 : res[i];
        end
      end
      FIN: begin
        for (int i = 0; i < NLANES; i++) begin
          op_c[i] = x[i];
          op_a[i] = ky[i];
          op_b[i] = ONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sat_now  = sat_acc | (|lane_sat);
    stp_next = (stp == IK1) ? PN_FIRST : stp + 1'b1;
  end

  assign idle = state == S_IDLE;
  assign done = state == S_HOLD;
  assign est  = x;

  // Sequencer, state and result merge.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      stp     <= PR_X;
      ph      <= 2'd0;
      sat_acc <= 1'b0;
      status  <= ST_OK;
      func_q  <= FUNC_PREDICT;
      for (int i = 0; i < NLANES; i++) begin
        x[i] <= '0;
        for (int j = 0; j < NLANES; j++) begin
          p[i][j] <= (i == j) ? ONE : '0;
        end
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_q  <= func;
            zx_q    <= zx;
            zy_q    <= zy;
            sat_acc <= (func == FUNC_UPDATE) && z_sat;
            stp     <= (func == FUNC_UPDATE) ? U_Y : PR_X;
            ph      <= 2'd0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          if (ph != PH_LAST) begin
            ph <= ph + 1'b1;
          end else begin
            ph      <= 2'd0;
            sat_acc <= sat_now;
            stp     <= stp_next;
            unique case (stp) inside
              PR_X: begin
                for (int i = 0; i < NLANES; i++) x[i] <= res[i];
              end
              PR_R0: begin
                for (int j = 0; j < NLANES; j++) p[0][j] <= res[j];
              end
              PR_R1: begin
                for (int j = 0; j < NLANES; j++) p[1][j] <= res[j];
              end
              PR_C0: begin
                for (int i = 0; i < NLANES; i++) p[i][0] <= res[i];
              end
              PR_C1: begin
                for (int i = 0; i < NLANES; i++) p[i][1] <= res[i];
              end
              PR_DQ: begin
                for (int i = 0; i < NLANES; i++) p[i][i] <= res[i];
                status <= sat_now ? ST_SAT : ST_OK;
                state  <= S_HOLD;
              end
              U_Y: begin
                y0 <= res[0];
                y1 <= res[1];
                s0 <= res[2];
                s3 <= res[3];
              end
              U_DM: begin
                m0  <= res[0];
                m1  <= res[1];
                ns1 <= res[2];
                ns2 <= res[3];
              end
              U_DET: begin
                det <= res[0];
                if (res[0] == '0) begin
                  status <= ST_SINGULAR;
                  state  <= S_HOLD;
                end else begin
                  state <= S_DIVGO;
                end
              end
              K0A, K0B, IK0: begin
                for (int i = 0; i < NLANES; i++) kk[i][0] <= res[i];
              end
              K1A, K1B, IK1: begin
                for (int i = 0; i < NLANES; i++) kk[i][1] <= res[i];
              end
              KYA, KYB: begin
                for (int i = 0; i < NLANES; i++) ky[i] <= res[i];
              end
              [PN_FIRST:PN_LAST]: begin
                if (pn_k == 2'd3) begin
                  for (int i = 0; i < NLANES; i++) t[i][pn_j] <= res[i];
                end
              end
              FIN: begin
                for (int i = 0; i < NLANES; i++) x[i] <= res[i];
                p      <= t;
                status <= sat_now ? ST_SAT : ST_OK;
                state  <= S_HOLD;
              end
              default: ;
            endcase
          end
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_busy == '0) begin
            si      <= div_q;
            sat_acc <= sat_acc | (|div_sat);
            stp     <= K0A;
            ph      <= 2'd0;
            state   <= S_STEP;
          end
        end
        S_HOLD: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The step phase never reaches its unused code.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (ph != 2'd3))
    else $error("step phase out of range");

  // All four dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVWAIT) |-> (div_busy == '0 || div_busy == '1))
    else $error("divider lanes out of step");

  // A singular innovation can come only from an update request.
  a_singular_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && status == ST_SINGULAR) |-> (func_q == FUNC_UPDATE))
    else $error("singular status on a predict request");

  // The result is taken only while one is held.
  a_ack_held: assert property (@(posedge clk) disable iff (rst)
    ack |-> (state == S_HOLD))
    else $error("result taken with none pending");

endmodule

`default_nettype wire

// File: rtl/core/kalman_filter_const_velocity_2d.sv
// Top level of the 2-D constant-velocity Kalman filter with stream and configuration ports.
`timescale 1ns / 1ps
`default_nettype none

// Tracks position and velocity in x and y with saturating signed fixed-point
// arithmetic. Each request on the input stream is either a predict (tuser 0)
// or a position measurement update (tuser 1); each produces exactly one result
// carrying the new estimate and a status (ok, singular innovation with the
// update skipped, or saturation somewhere in the request). Four lanes, one per
// state element, each with a multiply-accumulate unit and a one-bit-per-cycle
// divider, are driven by a microcoded sequencer. A predict is carried out in 6
// lane steps. An update is carried out in 28 lane steps with one divider run
// between the determinant and the gains; an update with a singular innovation
// returns after the determinant step. One request is processed at a time; the
// next one is accepted as soon as the previous result sits in the output
// register. The user must see that the noise registers are written only while
// no request is in flight; the block itself does not enforce this.
module kalman_filter_const_velocity_2d
  import kfcv_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: meas_pos_x [31:0], meas_pos_y [63:32]
  input  wire logic [2*IO_BITS-1:0]     s_axis_tdata,
  // tuser: func [0]
  input  wire logic [0:0]               s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // tdata: est_pos_x [31:0], est_pos_y [63:32], est_vel_x [95:64], est_vel_y [127:96]
  output logic [NLANES*IO_BITS-1:0]     m_axis_tdata,
  // tuser: status [1:0]
  output logic [1:0]                    m_axis_tuser,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CFG_BITS-1:0]      cfg_data
);

  localparam int W   = WORD_BITS;
  localparam int EXT = (W > IO_BITS) ? W : IO_BITS;
  localparam logic signed [EXT-1:0] WMAX_E = {{(EXT-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EXT-1:0] WMIN_E = ~WMAX_E;
  localparam logic signed [W-1:0]   WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   WMIN   = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] q_noise, r_noise;
  logic signed [W-1:0] zx, zy, est [NLANES];
  logic signed [EXT-1:0] zx_e, zy_e, cfg_e;
  logic signed [W-1:0] cfg_w;
  logic                z_sat, core_idle, core_done, ack, out_free, start;
  logic [1:0]          core_status;

  // Measurements widened and saturated to the word range.
  always_comb begin
    zx_e = EXT'($signed(s_axis_tdata[IO_BITS-1:0]));
    zy_e = EXT'($signed(s_axis_tdata[2*IO_BITS-1:IO_BITS]));
    zx   = (zx_e > WMAX_E) ? WMAX : (zx_e < WMIN_E) ? WMIN : zx_e[W-1:0];
    zy   = (zy_e > WMAX_E) ? WMAX : (zy_e < WMIN_E) ? WMIN : zy_e[W-1:0];
    z_sat = (zx_e > WMAX_E) || (zx_e < WMIN_E) || (zy_e > WMAX_E) || (zy_e < WMIN_E);
    cfg_e = $signed(EXT'(cfg_data));
    cfg_w = (cfg_e > WMAX_E) ? WMAX : cfg_e[W-1:0];
  end

  // Noise registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= W'(NOISE_RESET);
      r_noise <= W'(NOISE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index[0])
        CFG_IDX_Q: q_noise <= cfg_w;
        default:   r_noise <= cfg_w;
      endcase
    end
  end

  assign s_axis_tready = core_idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign ack           = core_done && out_free;

  kfcv_core #(.W(W), .F(FRAC_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (s_axis_tuser[0]),
    .zx     (zx),
    .zy     (zy),
    .z_sat  (z_sat),
    .q_noise(q_noise),
    .r_noise(r_noise),
    .idle   (core_idle),
    .done   (core_done),
    .ack    (ack),
    .est    (est),
    .status (core_status)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ack) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (ack) begin
      for (int i = 0; i < NLANES; i++) begin
        m_axis_tdata[i*IO_BITS +: IO_BITS] <= IO_BITS'(EXT'(est[i]));
      end
      m_axis_tuser <= core_status;
    end
  end

endmodule

`default_nettype wire
